>>> hdl/sdsm_pkg.sv
`timescale 1ns / 1ps
// shared constants, command codes and controller/datapath bundles
// for the squared-difference string matcher; no dependencies

package sdsm_pkg;

   localparam int MAX_PATTERN = 32;
   localparam int PAT_IDX_W   = $clog2(MAX_PATTERN);
   localparam int LEN_W       = 6;
   localparam int SYM_W       = 8;
   localparam int CMD_W       = 2;
   localparam int POS_W       = 32;
   localparam int SQ_W        = 2 * SYM_W;
   localparam int DIST_W      = 21;

   // largest sum the pattern can give: every byte off by 255
   localparam logic [DIST_W-1:0] DIST_BOUND = DIST_W'(MAX_PATTERN * 255 * 255);

   localparam logic [LEN_W-1:0] LEN_MIN = LEN_W'(1);
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PATTERN);

   localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_TEXT    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

   typedef struct packed {
      logic                 load;
      logic                 text;
      logic                 restart;
      logic                 issue;
      logic [PAT_IDX_W-1:0] rd_idx;
      logic                 mul_en;
      logic                 acc_en;
      logic                 load_out;
   } sdsm_cmd_type;

   typedef struct packed {
      logic                 hit;
      logic [PAT_IDX_W-1:0] len_m1;
      logic                 out_free;
   } sdsm_status_type;

endpackage

>>> hdl/sdsm_ifs.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for request, response and csr write
// depends on sdsm_pkg

interface sdsm_req_if import sdsm_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CMD_W-1:0]     cmd;
   logic [SYM_W-1:0]     symbol;
   logic [PAT_IDX_W-1:0] pattern_index;

   modport source (output valid, cmd, symbol, pattern_index, input ready);
   modport sink   (input valid, cmd, symbol, pattern_index, output ready);
endinterface

interface sdsm_rsp_if import sdsm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              match;
   logic [POS_W-1:0]  start_position;
   logic [DIST_W-1:0] distance;

   modport source (output valid, match, start_position, distance, input ready);
   modport sink   (input valid, match, start_position, distance, output ready);
endinterface

interface sdsm_csr_if import sdsm_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [LEN_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

>>> hdl/squared_difference_string_match.sv
`timescale 1ns / 1ps
// Squared-difference string matcher. Pattern loads (cmd 0), restarts (cmd 2) and
// the unused code are each completed in the cycle that accepts them. A text byte
// (cmd 1) that completes a window of pattern_length bytes occupies the block from
// its acceptance to the next: after it is accepted, the controller walks the
// pattern byte by byte through a single 8x8 squarer and a 21-bit accumulator,
// then drains the two-stage read/multiply pipeline and loads the result
// register. That load waits for as long as an earlier result has not been taken.
// A text byte that does not yet fill the window completes when it is accepted.
// The result register lets a new item be accepted while a result waits.
// The csr write port is always ready; write it only while the block is idle.
// Depends on sdsm_pkg, sdsm_ifs, sdsm_ctrl and sdsm_datapath.

module squared_difference_string_match import sdsm_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   sdsm_req_if.sink  req_chan,
   sdsm_rsp_if.source rsp_chan,
   sdsm_csr_if.sink  csr_chan
);

   sdsm_cmd_type    cmd;
   sdsm_status_type status;

   sdsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_cmd   (req_chan.cmd),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   sdsm_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_symbol         (req_chan.symbol),
      .req_pattern_index  (req_chan.pattern_index),
      .csr_valid          (csr_chan.valid),
      .csr_data           (csr_chan.data),
      .csr_ready          (csr_chan.ready),
      .rsp_valid          (rsp_chan.valid),
      .rsp_ready          (rsp_chan.ready),
      .rsp_match          (rsp_chan.match),
      .rsp_start_position (rsp_chan.start_position),
      .rsp_distance       (rsp_chan.distance)
   );

endmodule

>>> hdl/sdsm_ctrl.sv
`timescale 1ns / 1ps
// sequencer: accepts items, steps through the pattern one byte a cycle,
// tracks the read/multiply/accumulate pipeline; depends on sdsm_pkg

module sdsm_ctrl import sdsm_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic [CMD_W-1:0] req_cmd,
   output logic            req_ready,
   input  sdsm_status_type status,
   output sdsm_cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_RUN   = 3'b010,
      S_DRAIN = 3'b100
   } state_type;

   state_type            state_ff, state_in;
   logic [PAT_IDX_W-1:0] k_ff, k_in;
   logic                 v1_ff, v1_in;
   logic                 v2_ff, v2_in;
   logic                 accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      cmd          = '0;
      cmd.load     = accept && (req_cmd == CMD_LOAD);
      cmd.text     = accept && (req_cmd == CMD_TEXT);
      cmd.restart  = accept && (req_cmd == CMD_RESTART);
      cmd.rd_idx   = k_ff;
      cmd.mul_en   = v1_ff;
      cmd.acc_en   = v2_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd.text && status.hit) begin
               state_in = S_RUN;
               k_in     = '0;
            end
         end
         S_RUN: begin
            cmd.issue = 1'b1;
            if (k_ff == status.len_m1) begin
               state_in = S_DRAIN;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            // sum is final once both pipeline stages are empty
            if (!v1_ff && !v2_ff && status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign v1_in = cmd.issue;
   assign v2_in = v1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         k_ff     <= '0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         v1_ff    <= v1_in;
         v2_ff    <= v2_in;
      end
   end

endmodule

>>> hdl/sdsm_datapath.sv
`timescale 1ns / 1ps
// pattern memory, text window, counters, squared-difference unit,
// accumulator and result register; depends on sdsm_pkg

module sdsm_datapath import sdsm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  sdsm_cmd_type         cmd,
   output sdsm_status_type      status,
   input  logic [SYM_W-1:0]     req_symbol,
   input  logic [PAT_IDX_W-1:0] req_pattern_index,
   input  logic                 csr_valid,
   input  logic [LEN_W-1:0]     csr_data,
   output logic                 csr_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_match,
   output logic [POS_W-1:0]     rsp_start_position,
   output logic [DIST_W-1:0]    rsp_distance
);

   logic [LEN_W-1:0]     plen_ff;
   logic [LEN_W-1:0]     len;
   logic [PAT_IDX_W-1:0] len_m1;
   logic [SYM_W-1:0]     pat_mem [MAX_PATTERN];
   logic [SYM_W-1:0]     window_ff [MAX_PATTERN];
   logic [POS_W-1:0]     count_ff, count_in;
   logic [LEN_W-1:0]     fill_ff, fill_in, fill_next;
   logic [POS_W-1:0]     start_ff;
   logic [SYM_W-1:0]     pat_rd_ff;
   logic [SYM_W-1:0]     win_rd_ff;
   logic [SYM_W-1:0]     diff;
   logic [SQ_W-1:0]      sq_ff;
   logic [DIST_W-1:0]    acc_ff, acc_in;
   logic                 out_valid_ff, out_valid_in;
   logic                 out_match_ff;
   logic [POS_W-1:0]     out_start_ff;
   logic [DIST_W-1:0]    out_dist_ff;

   assign csr_ready = 1'b1;

   // a length of zero acts as one, anything above the store size as the size
   always_comb begin
      if (plen_ff < LEN_MIN) begin
         len = LEN_MIN;
      end else if (plen_ff > LEN_MAX) begin
         len = LEN_MAX;
      end else begin
         len = plen_ff;
      end
   end
   assign len_m1 = PAT_IDX_W'(len - LEN_MIN);

   assign fill_next = (fill_ff == LEN_MAX) ? fill_ff : fill_ff + 1'b1;

   assign status.hit      = (fill_next >= len);
   assign status.len_m1   = len_m1;
   assign status.out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      count_in = count_ff;
      fill_in  = fill_ff;
      if (cmd.restart) begin
         count_in = '0;
         fill_in  = '0;
      end else if (cmd.text) begin
         count_in = count_ff + 1'b1;
         fill_in  = fill_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff  <= LEN_MIN;
         count_ff <= '0;
         fill_ff  <= '0;
      end else begin
         if (csr_valid) begin
            plen_ff <= csr_data;
         end
         count_ff <= count_in;
         fill_ff  <= fill_in;
      end
   end

   // pattern memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pat_mem[req_pattern_index] <= req_symbol;
      end
      if (cmd.issue) begin
         pat_rd_ff <= pat_mem[cmd.rd_idx];
      end
   end

   // entry 0 holds the newest text byte
   always_ff @(posedge clock) begin
      if (cmd.text) begin
         window_ff[0] <= req_symbol;
         for (int i = 1; i < MAX_PATTERN; i++) begin
            window_ff[i] <= window_ff[i-1];
         end
      end
      if (cmd.issue) begin
         win_rd_ff <= window_ff[len_m1 - cmd.rd_idx];
      end
   end

   // start = count after this byte minus length
   always_ff @(posedge clock) begin
      if (cmd.text) begin
         start_ff <= count_ff - POS_W'(len_m1);
      end
   end

   assign diff = (win_rd_ff > pat_rd_ff) ? win_rd_ff - pat_rd_ff : pat_rd_ff - win_rd_ff;

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         sq_ff <= diff * diff;
      end
   end

   // the sum never exceeds the 21-bit range, so no clamp is needed
   always_comb begin
      acc_in = acc_ff;
      if (cmd.text) begin
         acc_in = '0;
      end else if (cmd.acc_en) begin
         acc_in = acc_ff + DIST_W'(sq_ff);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_match_ff <= (acc_ff == '0);
         out_start_ff <= start_ff;
         out_dist_ff  <= acc_ff;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_match          = out_match_ff;
   assign rsp_start_position = out_start_ff;
   assign rsp_distance       = out_dist_ff;

endmodule

>>> hdl/sdsm_checker.sv
`timescale 1ns / 1ps
// port-level checks for the string matcher, bound to the top level
// depends on sdsm_pkg and squared_difference_string_match

module sdsm_checker import sdsm_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic [CMD_W-1:0]  req_cmd,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              rsp_match,
   input logic [POS_W-1:0]  rsp_start_position,
   input logic [DIST_W-1:0] rsp_distance
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_distance)
         && $stable(rsp_start_position) && $stable(rsp_match))
      else $error("stalled result changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_match == (rsp_distance == '0)))
      else $error("match flag disagrees with distance");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_distance <= DIST_BOUND))
      else $error("distance above largest possible sum");

   // loads and restarts never cause a result
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_cmd != CMD_TEXT) |=> !$rose(rsp_valid))
      else $error("result after a non-text item");

endmodule

bind squared_difference_string_match sdsm_checker u_sdsm_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_chan.valid),
   .req_ready          (req_chan.ready),
   .req_cmd            (req_chan.cmd),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_match          (rsp_chan.match),
   .rsp_start_position (rsp_chan.start_position),
   .rsp_distance       (rsp_chan.distance)
);
